[hw/rtl/nbr_tbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbr_tbl_pkg - shared types and constants of the neighbour table
// Table size, command and result codes, transaction payloads and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package nbr_tbl_pkg;

	// table geometry
	localparam int TABLE_SLOTS = 32;
	localparam int MAX_RESULTS = 32;
	localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int PTR_W       = $clog2(TABLE_SLOTS + 1);
	localparam int LIST_W      = $clog2(MAX_RESULTS + 1);

	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	// request commands
	localparam logic [1:0] CMD_BEACON  = 2'd0;
	localparam logic [1:0] CMD_CLEANUP = 2'd1;
	localparam logic [1:0] CMD_LIST    = 2'd2;

	// result status codes
	localparam logic [2:0] RES_UPDATED    = 3'd0;
	localparam logic [2:0] RES_INSERTED   = 3'd1;
	localparam logic [2:0] RES_FULL       = 3'd2;
	localparam logic [2:0] RES_CLEANED    = 3'd3;
	localparam logic [2:0] RES_LIST_ENTRY = 3'd4;
	localparam logic [2:0] RES_LIST_EMPTY = 3'd5;

	typedef struct packed {
		logic [1:0]         command;
		logic [47:0]        sender_id;
		logic [31:0]        now_ticks;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] neighbor_id;
		logic [15:0] beacon_count;
		logic [5:0]  removed_count;
		logic        last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic stage_blocked;
		logic out_room;
	} dp_status_t;

endpackage

[hw/rtl/neighbor_table_with_aging.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_table_with_aging - neighbour table keyed by 48-bit address
// Records beacons, ages out stale entries on a cleanup sweep and lists
// the stored neighbour ids in slot order.
//
//  channel | handshake            | payload
//  req     | req_valid/req_stall  | item_t: command, sender, time, pos, vel
//  rsp     | rsp_valid/rsp_stall  | result_t: status, id, count, removed, last
//  cfg     | cfg_valid/cfg_ready  | cfg_timeout, 32-bit age limit
//
// Each request runs through a full slot scan from acceptance to the next
// acceptance: the single-port slot record memory is read one slot per cycle
// while no list entry waits for room in the output register. A request is also
// held up while a result it must place waits behind a result held by rsp_stall.
// Reset empties the table at once and sets the timeout to 1000 ticks.
// A finished result waits in the output register while a new request is taken.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  nbr_tbl_pkg::item_t   req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output nbr_tbl_pkg::result_t rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_timeout
);
	import nbr_tbl_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       cfg_we;

	// register writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	nbr_tbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	nbr_tbl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req         (req),
		.cfg_we      (cfg_we),
		.cfg_timeout (cfg_timeout),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp)
	);

endmodule

[hw/rtl/nbr_tbl_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbr_tbl_dp - neighbour table datapath
// Slot record memory, valid flags, scan stage (one slot per cycle unless stalled),
// sweep accumulators, final write-back and the registered result transaction.
// ----------------------------------------------------------------------------
module nbr_tbl_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nbr_tbl_pkg::ctrl_cmd_t  cmd,
	output nbr_tbl_pkg::dp_status_t status,
	input  nbr_tbl_pkg::item_t      req,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_timeout,
	input  logic                    rsp_stall,
	output logic                    rsp_valid,
	output nbr_tbl_pkg::result_t    rsp
);
	import nbr_tbl_pkg::*;

	typedef struct packed {
		logic [47:0] id;
		logic [31:0] last_time;
		logic [15:0] count;
	} rec_t;

	// storage
	rec_t                   rec_mem [TABLE_SLOTS];
	logic [191:0]           kin_mem [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [31:0]            timeout_q;
	item_t                  item_q;

	// scan stage
	logic [PTR_W-1:0]  ptr_q;
	logic              vld_s1_q;
	logic [SLOT_W-1:0] slot_s1;
	logic              occ_s1;
	rec_t              rec_s1;

	// accumulators
	logic              hit_q;
	logic              free_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [SLOT_W-1:0] free_slot_q;
	logic [15:0]       hit_cnt_q;
	logic [5:0]        removed_q;
	logic [LIST_W-1:0] list_n_q;

	// output register
	logic    out_valid_q;
	result_t out_q;

	logic              is_beacon, is_cleanup, is_list;
	logic              issue, rd_en, ev;
	logic              match_s1, expire_s1, more_s1, emit_s1;
	logic [31:0]       age_s1;
	logic              out_room;
	logic              rec_we;
	logic [SLOT_W-1:0] wr_slot;
	logic [15:0]       new_cnt;
	logic              res_load;
	result_t           res_d;

	// command decode
	assign is_beacon  = (item_q.command == CMD_BEACON);
	assign is_cleanup = (item_q.command == CMD_CLEANUP);
	assign is_list    = (item_q.command == CMD_LIST);

	assign issue = (ptr_q < PTR_W'(TABLE_SLOTS));
	assign rd_en = cmd.step && issue;
	assign ev    = cmd.step && vld_s1_q;

	// slot evaluation
	assign match_s1  = occ_s1 && (rec_s1.id == item_q.sender_id);
	assign age_s1    = item_q.now_ticks - rec_s1.last_time;
	assign expire_s1 = occ_s1 && (age_s1 > timeout_q);
	assign emit_s1   = is_list && vld_s1_q && occ_s1 && (list_n_q < LIST_W'(MAX_RESULTS));

	// any valid slot after the one in the stage
	always_comb begin
		more_s1 = 1'b0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (valid_q[i] && ((SLOT_W+1)'(i) > {1'b0, slot_s1}))
				more_s1 = 1'b1;
		end
	end

	assign out_room = !out_valid_q || !rsp_stall;

	assign status.scan_done     = (ptr_q == PTR_W'(TABLE_SLOTS)) && !vld_s1_q;
	assign status.stage_blocked = emit_s1 && !out_room;
	assign status.out_room      = out_room;

	// write-back of a beacon
	assign rec_we  = cmd.finish && is_beacon && (hit_q || free_q);
	assign wr_slot = hit_q ? hit_slot_q : free_slot_q;
	assign new_cnt = hit_q ? ((hit_cnt_q == 16'hFFFF) ? hit_cnt_q : hit_cnt_q + 16'd1)
	                       : 16'd1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_timeout;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= req;
	end

	// record memory, registered read
	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[wr_slot] <= '{id: item_q.sender_id, last_time: item_q.now_ticks,
			                      count: new_cnt};
			kin_mem[wr_slot] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z,
			                     item_q.vel_x, item_q.vel_y, item_q.vel_z};
		end
		if (rd_en) begin
			rec_s1  <= rec_mem[ptr_q[SLOT_W-1:0]];
			slot_s1 <= ptr_q[SLOT_W-1:0];
			occ_s1  <= valid_q[ptr_q[SLOT_W-1:0]];
		end
	end

	// scan pointer and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			vld_s1_q <= 1'b0;
		end else if (cmd.load) begin
			ptr_q    <= '0;
			vld_s1_q <= 1'b0;
		end else if (cmd.step) begin
			vld_s1_q <= issue;
			if (issue)
				ptr_q <= ptr_q + PTR_W'(1);
		end
	end

	// sweep flags and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
			list_n_q  <= '0;
		end else if (cmd.load) begin
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			removed_q <= '0;
			list_n_q  <= '0;
		end else if (ev) begin
			if (is_beacon && match_s1)
				hit_q <= 1'b1;
			if (is_beacon && !occ_s1)
				free_q <= 1'b1;
			if (is_cleanup && expire_s1 && (removed_q != 6'h3F))
				removed_q <= removed_q + 6'd1;
			if (emit_s1)
				list_n_q <= list_n_q + LIST_W'(1);
		end
	end

	// first matching and first free slot
	always_ff @(posedge clk) begin
		if (ev && is_beacon && match_s1 && !hit_q) begin
			hit_slot_q <= slot_s1;
			hit_cnt_q  <= rec_s1.count;
		end
		if (ev && is_beacon && !occ_s1 && !free_q)
			free_slot_q <= slot_s1;
	end

	// slot valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ev && is_cleanup && expire_s1)
				valid_q[slot_s1] <= 1'b0;
			if (cmd.finish && is_beacon && !hit_q && free_q)
				valid_q[free_slot_q] <= 1'b1;
		end
	end

	// result selection
	always_comb begin
		res_load = 1'b0;
		res_d    = '0;
		if (ev && emit_s1) begin
			res_load           = 1'b1;
			res_d.status       = RES_LIST_ENTRY;
			res_d.neighbor_id  = rec_s1.id;
			res_d.beacon_count = rec_s1.count;
			res_d.last         = !more_s1 || (list_n_q == LIST_W'(MAX_RESULTS - 1));
		end else if (cmd.finish) begin
			case (item_q.command)
				CMD_BEACON: begin
					res_load          = 1'b1;
					res_d.neighbor_id = item_q.sender_id;
					res_d.last        = 1'b1;
					if (hit_q || free_q) begin
						res_d.status       = hit_q ? RES_UPDATED : RES_INSERTED;
						res_d.beacon_count = new_cnt;
					end else begin
						res_d.status = RES_FULL;
					end
				end
				CMD_CLEANUP: begin
					res_load            = 1'b1;
					res_d.status        = RES_CLEANED;
					res_d.removed_count = removed_q;
					res_d.last          = 1'b1;
				end
				CMD_LIST: begin
					if (list_n_q == '0) begin
						res_load     = 1'b1;
						res_d.status = RES_LIST_EMPTY;
						res_d.last   = 1'b1;
					end
				end
				default: begin
					res_load = 1'b0;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			out_q <= res_d;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef NO_ASSERTIONS
	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_room)
		else $error("result register overwritten while stalled");

	// scan pointer stays within the table
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(TABLE_SLOTS))
		else $error("scan pointer beyond table");

	// an insert only claims a free slot
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && is_beacon && !hit_q && free_q) |-> !valid_q[free_slot_q])
		else $error("insert into occupied slot");

	// an expired slot is freed
	a_expire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ev && is_cleanup && expire_s1) |=> !valid_q[$past(slot_s1)])
		else $error("expired slot still valid");
`endif

endmodule

[hw/rtl/nbr_tbl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbr_tbl_ctrl - neighbour table sequencer
// Takes one request transaction, steps the slot scan and triggers the
// closing write-back and result once the result register has room.
// ----------------------------------------------------------------------------
module nbr_tbl_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  nbr_tbl_pkg::dp_status_t status,
	output nbr_tbl_pkg::ctrl_cmd_t  cmd
);
	import nbr_tbl_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = !status.stage_blocked;
				if (status.scan_done)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_room) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	// closing step only when the result register can take it
	a_finish_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> status.out_room)
		else $error("finish issued without result room");

	// an accepted request always starts a scan
	a_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_SCAN))
		else $error("request accepted without scan");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking testbench of the neighbour table with ageing
// Sends beacon, cleanup and list requests, predicts every result from a
// model of the slot table kept in the bench and compares each result field
// by field. Covers the empty and the full table, ageing with time wrap,
// timeout changes, back-pressure on both channels and repeated beacons.
// ----------------------------------------------------------------------------
module tb_top;
	import nbr_tbl_pkg::*;

	localparam logic [1:0]  CMD_UNUSED     = 2'd3;
	localparam int          POOL_IDS       = 40;
	localparam int          SETTLE_CYCLES  = TABLE_SLOTS + 8;
	localparam int          LONG_HOLD      = 400;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          ROUND_ITEMS    = 20;
	localparam int          REPEAT_BEACONS = 24;
	localparam logic [47:0] FILL_BASE      = 48'h0100_0000_0000;
	localparam logic [47:0] REPEAT_ID      = 48'h1357_9BDF_2468;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        req_valid   = 1'b0;
	logic        req_stall;
	item_t       req         = '0;
	logic        rsp_valid;
	logic        rsp_stall   = 1'b0;
	result_t     rsp;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_timeout = '0;

	// bench copy of the slot table and the timeout register
	logic        nb_valid [TABLE_SLOTS];
	logic [47:0] nb_id    [TABLE_SLOTS];
	logic [31:0] nb_time  [TABLE_SLOTS];
	logic [15:0] nb_count [TABLE_SLOTS];
	logic [31:0] age_limit;

	result_t     expected_results [$];
	result_t     want_res;
	logic [47:0] id_pool [POOL_IDS];
	logic [31:0] clock_ticks;

	int fail_count   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int cfg_writes   = 0;
	int quiet_cycles = 0;
	int holds_asked  = 0;
	int holds_served = 0;
	int stall_left   = 0;
	bit tx_idling    = 1'b1;
	bit rx_idling    = 1'b1;

	neighbor_table_with_aging u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_timeout (cfg_timeout)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// table prediction
	// ------------------------------------------------------------------------
	function automatic result_t make_result(input logic [2:0] status, input logic [47:0] id,
			input logic [15:0] count, input logic [5:0] removed, input logic last);
		result_t r;
		r.status        = status;
		r.neighbor_id   = id;
		r.beacon_count  = count;
		r.removed_count = removed;
		r.last          = last;
		return r;
	endfunction

	function automatic void clear_table();
		for (int s = 0; s < TABLE_SLOTS; s++) begin
			nb_valid[s] = 1'b0;
			nb_id[s]    = '0;
			nb_time[s]  = '0;
			nb_count[s] = '0;
		end
		age_limit = TIMEOUT_RESET;
	endfunction

	// applies one accepted request to the table and queues its results
	function automatic void predict_table(input item_t it);
		int          hit;
		int          free_s;
		int          swept;
		int          listed;
		logic [31:0] age;
		result_t     held;
		bit          have_held;
		hit       = -1;
		free_s    = -1;
		swept     = 0;
		listed    = 0;
		have_held = 1'b0;
		held      = '0;
		case (it.command)
			CMD_BEACON: begin
				for (int s = 0; s < TABLE_SLOTS; s++) begin
					if (hit < 0 && nb_valid[s] && nb_id[s] == it.sender_id)
						hit = s;
					if (free_s < 0 && !nb_valid[s])
						free_s = s;
				end
				if (hit >= 0) begin
					nb_time[hit] = it.now_ticks;
					if (nb_count[hit] != 16'hFFFF)
						nb_count[hit] = nb_count[hit] + 16'd1;
					expected_results.push_back(make_result(RES_UPDATED, it.sender_id,
						nb_count[hit], 6'd0, 1'b1));
				end else if (free_s < 0) begin
					expected_results.push_back(make_result(RES_FULL, it.sender_id,
						16'd0, 6'd0, 1'b1));
				end else begin
					nb_valid[free_s] = 1'b1;
					nb_id[free_s]    = it.sender_id;
					nb_time[free_s]  = it.now_ticks;
					nb_count[free_s] = 16'd1;
					expected_results.push_back(make_result(RES_INSERTED, it.sender_id,
						16'd1, 6'd0, 1'b1));
				end
			end
			CMD_CLEANUP: begin
				for (int s = 0; s < TABLE_SLOTS; s++) begin
					age = it.now_ticks - nb_time[s];
					if (nb_valid[s] && age > age_limit) begin
						nb_valid[s] = 1'b0;
						swept++;
					end
				end
				if (swept > 63)
					swept = 63;
				expected_results.push_back(make_result(RES_CLEANED, '0, '0, 6'(swept), 1'b1));
			end
			CMD_LIST: begin
				// hold back each entry so the final one can carry the last flag
				for (int s = 0; s < TABLE_SLOTS; s++) begin
					if (nb_valid[s] && listed < MAX_RESULTS) begin
						if (have_held)
							expected_results.push_back(held);
						held      = make_result(RES_LIST_ENTRY, nb_id[s], nb_count[s], 6'd0, 1'b0);
						have_held = 1'b1;
						listed++;
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					expected_results.push_back(held);
				end else
					expected_results.push_back(make_result(RES_LIST_EMPTY, '0, '0, 6'd0, 1'b1));
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [47:0] random_id();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic item_t make_item(input logic [1:0] cmd, input logic [47:0] id,
			input logic [31:0] now);
		item_t it;
		it.command   = cmd;
		it.sender_id = id;
		it.now_ticks = now;
		it.pos_x     = $urandom;
		it.pos_y     = $urandom;
		it.pos_z     = $urandom;
		it.vel_x     = $urandom;
		it.vel_y     = $urandom;
		it.vel_z     = $urandom;
		return it;
	endfunction

	// beacon from the id pool at a slowly advancing time
	function automatic item_t random_beacon();
		clock_ticks = clock_ticks + $urandom_range(0, 40);
		return make_item(CMD_BEACON, id_pool[$urandom_range(0, POOL_IDS - 1)], clock_ticks);
	endfunction

	// offers one request, waits for acceptance, then maybe idles for a burst
	task automatic send_item(input item_t it);
		int gap;
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_table(it);
		if (it.command != CMD_UNUSED)
			items_sent++;
		gap = (tx_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// timeout write once the table has gone idle
	task automatic set_timeout(input logic [31:0] limit);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_timeout <= limit;
		cfg_valid   <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		age_limit = limit;
		cfg_writes++;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_empty_table();
		send_item(make_item(CMD_LIST, '0, '0));
		send_item(make_item(CMD_CLEANUP, '0, '0));
		// unused command leaves the table alone and answers nothing
		send_item(make_item(CMD_UNUSED, random_id(), $urandom));
		send_item(make_item(CMD_LIST, '0, 32'd1));
	endtask

	task automatic test_beacon_fields();
		item_t it;
		it = make_item(CMD_BEACON, 48'h0, 32'h0);
		it.pos_x = 32'sh8000_0000;
		it.pos_y = 32'sh8000_0000;
		it.pos_z = 32'sh8000_0000;
		it.vel_x = 32'sh8000_0000;
		it.vel_y = 32'sh8000_0000;
		it.vel_z = 32'sh8000_0000;
		send_item(it);
		it = make_item(CMD_BEACON, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		it.pos_x = 32'sh7FFF_FFFF;
		it.pos_y = 32'sh7FFF_FFFF;
		it.pos_z = 32'sh7FFF_FFFF;
		it.vel_x = 32'sh7FFF_FFFF;
		it.vel_y = 32'sh7FFF_FFFF;
		it.vel_z = 32'sh7FFF_FFFF;
		send_item(it);
		send_item(make_item(CMD_BEACON, 48'h0, 32'd20));
		send_item(make_item(CMD_BEACON, 48'hAAAA_AAAA_AAAA, 32'd30));
		send_item(make_item(CMD_BEACON, 48'h5555_5555_5555, 32'd40));
		send_item(make_item(CMD_BEACON, 48'hFFFF_FFFF_FFFF, 32'd50));
		send_item(make_item(CMD_LIST, '0, 32'd60));
	endtask

	task automatic test_ageing_rules();
		// age equal to the timeout stays, one more goes; ages wrap modulo 2^32
		set_timeout(32'd10);
		send_item(make_item(CMD_CLEANUP, '0, 32'd40));
		send_item(make_item(CMD_CLEANUP, '0, 32'd41));
		send_item(make_item(CMD_BEACON, 48'h1, 32'hFFFF_FFFA));
		send_item(make_item(CMD_CLEANUP, '0, 32'd4));
		send_item(make_item(CMD_CLEANUP, '0, 32'd5));
		// zero timeout removes anything at least one tick old
		set_timeout(32'd0);
		send_item(make_item(CMD_BEACON, 48'h2, 32'd100));
		send_item(make_item(CMD_CLEANUP, '0, 32'd100));
		send_item(make_item(CMD_CLEANUP, '0, 32'd101));
		// largest timeout never removes
		set_timeout(32'hFFFF_FFFF);
		send_item(make_item(CMD_BEACON, 48'h3, 32'd0));
		send_item(make_item(CMD_CLEANUP, '0, 32'hFFFF_FFFF));
		send_item(make_item(CMD_LIST, '0, 32'hFFFF_FFFF));
	endtask

	task automatic test_table_full();
		set_timeout(32'd0);
		send_item(make_item(CMD_CLEANUP, '0, 32'h1234_5678));
		set_timeout(TIMEOUT_RESET);
		for (int k = 0; k <= TABLE_SLOTS; k++)
			send_item(make_item(CMD_BEACON, FILL_BASE + 48'(k), 32'(5000 + k)));
		// update still works on a full table
		send_item(make_item(CMD_BEACON, FILL_BASE + 48'd7, 32'd5010));
		send_item(make_item(CMD_LIST, '0, 32'd5040));
		// every entry is over the timeout here
		send_item(make_item(CMD_CLEANUP, '0, 32'd6032));
		send_item(make_item(CMD_LIST, '0, 32'd6033));
	endtask

	task automatic test_backpressure();
		item_t it;
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		holds_asked++;
		for (int k = 0; k < 14; k++) begin
			it = random_beacon();
			if (k == 6)
				it.command = CMD_LIST;
			send_item(it);
		end
		// sender pauses until the table has answered everything
		wait_drained();
	endtask

	task automatic test_random_traffic();
		logic [31:0] limits [5];
		int          done;
		int          pick;
		item_t       it;
		limits = '{32'd5, 32'd60, 32'd400, 32'hFFFF_FFFF, 32'd0};
		limits[4] = $urandom;
		clock_ticks = 32'hFFFF_FC00;
		for (int round = 0; round < 5; round++) begin
			set_timeout(limits[round]);
			tx_idling = (round == 0) ? 1'b1 : 1'($urandom_range(0, 1));
			rx_idling = (round == 0) ? 1'b1 : 1'($urandom_range(0, 1));
			done = 0;
			while (done < ROUND_ITEMS) begin
				pick = $urandom_range(0, 99);
				it = random_beacon();
				if (pick >= 70 && pick < 80)
					it.command = CMD_CLEANUP;
				else if (pick >= 80 && pick < 90)
					it.command = CMD_LIST;
				else if (pick >= 90 && pick < 95)
					it.command = CMD_UNUSED;
				else if (pick >= 95) begin
					// stray beacon, any sender at any time
					it.sender_id = random_id();
					it.now_ticks = $urandom;
				end
				send_item(it);
				if (it.command != CMD_UNUSED)
					done++;
			end
		end
	endtask

	task automatic test_repeated_beacons();
		set_timeout(32'd0);
		send_item(make_item(CMD_CLEANUP, '0, clock_ticks ^ 32'h8000_0000));
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		// one sender again and again, count climbs by one each time
		for (int k = 0; k < REPEAT_BEACONS; k++)
			send_item(make_item(CMD_BEACON, REPEAT_ID, 32'(k)));
		send_item(make_item(CMD_LIST, '0, 32'd70000));
	endtask

	// ------------------------------------------------------------------------
	// receiver: random stall bursts and the long hold
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			stall_left   <= LONG_HOLD;
			rsp_stall    <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else if (rx_idling && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 16);
			rsp_stall  <= 1'b1;
		end else
			rsp_stall <= 1'b0;
	end

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result with none pending: status %0d id %0h", rsp.status, rsp.neighbor_id);
				fail_count++;
			end else begin
				want_res = expected_results.pop_front();
				check_field("status", 64'(want_res.status), 64'(rsp.status));
				check_field("neighbor_id", 64'(want_res.neighbor_id), 64'(rsp.neighbor_id));
				check_field("beacon_count", 64'(want_res.beacon_count), 64'(rsp.beacon_count));
				check_field("removed_count", 64'(want_res.removed_count), 64'(rsp.removed_count));
				check_field("last", 64'(want_res.last), 64'(rsp.last));
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		clear_table();
		clock_ticks = '0;
		for (int k = 0; k < POOL_IDS; k++)
			id_pool[k] = random_id();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_beacon_fields();
		test_ageing_rules();
		test_table_full();
		test_backpressure();
		test_random_traffic();
		test_repeated_beacons();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run: %0d requests, %0d results checked, %0d timeout writes",
			items_sent, results_seen, cfg_writes);
		$display("run: empty and full table, ageing with wrap, full list, stalls, repeat sender");
		if (fail_count == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
